FILE: hdl/rrw_pkg.sv
// Rotor-router walk engine: shared widths, depths, codes and memory request types.
// Used by the interfaces, the memories and the top level; depends on nothing.
package rrw_pkg;

  // Field widths
  localparam int NODE_W  = 8;
  localparam int SLOT_W  = 4;
  localparam int EDGE_W  = 9;
  localparam int DEG_W   = 5;
  localparam int MODE_W  = 2;
  localparam int STEP_W  = 31;
  localparam int NCNT_W  = 9;
  localparam int ECNT_W  = 10;
  localparam int STAT_W  = 3;
  localparam int CIDX_W  = 2;
  localparam int CDAT_W  = 10;

  // Table geometry
  localparam int MAX_NODES  = 256;
  localparam int MAX_DEGREE = 16;
  localparam int MAX_EDGES  = 512;
  localparam int SLOT_AW    = NODE_W + SLOT_W;
  localparam int SLOT_DEPTH = MAX_NODES * MAX_DEGREE;
  localparam int CLR_W      = EDGE_W;

  localparam logic [STEP_W-1:0] STEP_LIMIT = {STEP_W{1'b1}};

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD_SLOT  = 2'd0,
    MODE_SET_DEGREE = 2'd1,
    MODE_START      = 2'd2,
    MODE_STEP       = 2'd3
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_MOVING   = 3'd0,
    STAT_COMPLETE = 3'd1,
    STAT_SINK     = 3'd2,
    STAT_LIMIT    = 3'd3,
    STAT_LOAD_ACK = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    STOP_NONE     = 2'd0,
    STOP_COMPLETE = 2'd1,
    STOP_SINK     = 2'd2,
    STOP_LIMIT    = 2'd3
  } stop_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_SOURCE   = 2'd0,
    CFG_TGT_NODE = 2'd1,
    CFG_TGT_EDGE = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_VERT,
    FSM_SLOT,
    FSM_SEEN,
    FSM_EMIT
  } fsm_t;

  // Adjacency slot entry and vertex entry
  typedef struct packed {
    logic [NODE_W-1:0] neighbor;
    logic [EDGE_W-1:0] edge_id;
  } slot_ent_t;

  typedef struct packed {
    logic [DEG_W-1:0]  deg;
    logic [SLOT_W-1:0] rot;
  } vert_ent_t;

  typedef struct packed {
    logic             we;
    logic             re;
    logic [SLOT_AW-1:0] addr;
    slot_ent_t        wdata;
  } slot_req_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [NODE_W-1:0] addr;
    vert_ent_t         wdata;
  } vert_req_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [NODE_W-1:0] addr;
    logic              wbit;
  } node_req_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [EDGE_W-1:0] addr;
    logic              wbit;
  } edge_req_t;

endpackage

FILE: hdl/rrw_if.sv
// Valid/ready channel interfaces for the walk engine: item in, result out, config write.
// Depends on rrw_pkg for field widths.
interface rrw_in_if import rrw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [NODE_W-1:0] vertex;
  logic [SLOT_W-1:0] slot;
  logic [NODE_W-1:0] neighbor;
  logic [EDGE_W-1:0] edge_index;
  logic [DEG_W-1:0]  degree;

  modport source (output valid, mode, vertex, slot, neighbor, edge_index, degree,
                  input ready);
  modport sink   (input valid, mode, vertex, slot, neighbor, edge_index, degree,
                  output ready);
endinterface

interface rrw_out_if import rrw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [EDGE_W-1:0] edge_id;
  logic [NODE_W-1:0] arrival_vertex;
  logic [STEP_W-1:0] step_number;
  logic              first_node_visit;
  logic              first_edge_visit;
  logic [NCNT_W-1:0] nodes_seen;
  logic [ECNT_W-1:0] edges_seen;
  logic [STAT_W-1:0] status;

  modport source (output valid, edge_id, arrival_vertex, step_number, first_node_visit,
                  first_edge_visit, nodes_seen, edges_seen, status, input ready);
  modport sink   (input valid, edge_id, arrival_vertex, step_number, first_node_visit,
                  first_edge_visit, nodes_seen, edges_seen, status, output ready);
endinterface

interface rrw_cfg_if import rrw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  logic [CDAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/rrw_adj_mem.sv
// Adjacency store: slot table (neighbor, edge id) and per-vertex degree/rotor table.
// Single-port synchronous memories with registered read; types from rrw_pkg.
module rrw_adj_mem import rrw_pkg::*; (
  input  logic      clk,
  input  slot_req_t slot_req,
  output slot_ent_t slot_rd,
  input  vert_req_t vert_req,
  output vert_ent_t vert_rd
);

  slot_ent_t slot_mem [SLOT_DEPTH];
  vert_ent_t vert_mem [MAX_NODES];
  slot_ent_t slot_rd_r;
  vert_ent_t vert_rd_r;

  // Slot table: write or read one entry per cycle
  always_ff @(posedge clk) begin
    if (slot_req.we) begin
      slot_mem[slot_req.addr] <= slot_req.wdata;
    end
    if (slot_req.re) begin
      slot_rd_r <= slot_mem[slot_req.addr];
    end
  end

  // Vertex table: degree and rotor travel together
  always_ff @(posedge clk) begin
    if (vert_req.we) begin
      vert_mem[vert_req.addr] <= vert_req.wdata;
    end
    if (vert_req.re) begin
      vert_rd_r <= vert_mem[vert_req.addr];
    end
  end

  assign slot_rd = slot_rd_r;
  assign vert_rd = vert_rd_r;

  // Rotor written back always points inside the vertex's schedule
  a_rotor_in_range: assert property (@(posedge clk)
    vert_req.we |-> ({1'b0, vert_req.wdata.rot} < vert_req.wdata.deg) ||
                    (vert_req.wdata.deg == '0 && vert_req.wdata.rot == '0))
    else $error("rotor written outside degree");

  // A read issued this cycle sees a stable entry: no same-cycle write on the port
  a_vert_no_collide: assert property (@(posedge clk)
    vert_req.re |-> !vert_req.we)
    else $error("vertex table read and write in one cycle");

endmodule

FILE: hdl/rrw_seen_mem.sv
// Seen-node and seen-edge bit maps of the walk, cleared by a sweep from the controller.
// Single-port synchronous memories with registered read; types from rrw_pkg.
module rrw_seen_mem import rrw_pkg::*; (
  input  logic      clk,
  input  node_req_t node_req,
  output logic      node_rd,
  input  edge_req_t edge_req,
  output logic      edge_rd
);

  logic node_map [MAX_NODES];
  logic edge_map [MAX_EDGES];
  logic node_rd_r;
  logic edge_rd_r;

  // Node map port
  always_ff @(posedge clk) begin
    if (node_req.we) begin
      node_map[node_req.addr] <= node_req.wbit;
    end
    if (node_req.re) begin
      node_rd_r <= node_map[node_req.addr];
    end
  end

  // Edge map port
  always_ff @(posedge clk) begin
    if (edge_req.we) begin
      edge_map[edge_req.addr] <= edge_req.wbit;
    end
    if (edge_req.re) begin
      edge_rd_r <= edge_map[edge_req.addr];
    end
  end

  assign node_rd = node_rd_r;
  assign edge_rd = edge_rd_r;

endmodule

FILE: hdl/rotor_router_walk_engine_top.sv
// Rotor-router walk engine top: config registers, walk controller and output register.
// Instantiates rrw_adj_mem and rrw_seen_mem; uses rrw_pkg and the rrw_if interfaces.
//
//   channel    direction  carries                                     handshake
//   in_chan    in         mode, vertex, slot, neighbor, edge, degree  valid/ready
//   out_chan   out        edge, arrival, step, flags, counts, status  valid/ready
//   cfg_chan   in         register index, write data                  valid/ready
//
// A load or degree transaction goes straight to the result stage. A step that moves
// passes rotor read, slot read, seen-map read and update, then the result stage; a step
// at a sink passes rotor read and the result stage; a step after a stop goes straight
// to the result stage; one transaction at a time. A start then runs a 512-entry sweep
// of the seen maps, no input taken; the reset sweep also clears the degree/rotor table.
// A stalled output holds its result; the next transaction is taken meanwhile and
// its result waits in the result stage until the output register frees.
module rotor_router_walk_engine_top import rrw_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  rrw_in_if.sink          in_chan,
  rrw_out_if.source       out_chan,
  rrw_cfg_if.sink         cfg_chan
);

  typedef struct packed {
    logic [EDGE_W-1:0] edge_id;
    logic [NODE_W-1:0] arrival_vertex;
    logic [STEP_W-1:0] step_number;
    logic              first_node_visit;
    logic              first_edge_visit;
    logic [NCNT_W-1:0] nodes_seen;
    logic [ECNT_W-1:0] edges_seen;
    status_t           status;
  } result_t;

  function automatic result_t mk_res(
    input logic [EDGE_W-1:0] e,
    input logic [NODE_W-1:0] a,
    input logic [STEP_W-1:0] s,
    input logic              fn,
    input logic              fe,
    input logic [NCNT_W-1:0] nc,
    input logic [ECNT_W-1:0] ec,
    input status_t           st
  );
    result_t r;
    r.edge_id          = e;
    r.arrival_vertex   = a;
    r.step_number      = s;
    r.first_node_visit = fn;
    r.first_edge_visit = fe;
    r.nodes_seen       = nc;
    r.edges_seen       = ec;
    r.status           = st;
    return r;
  endfunction

  fsm_t              state_r, state_nxt;
  logic [NODE_W-1:0] src_r, src_nxt;
  logic [NCNT_W-1:0] tgt_node_r, tgt_node_nxt;
  logic [ECNT_W-1:0] tgt_edge_r, tgt_edge_nxt;
  logic [NODE_W-1:0] pos_r, pos_nxt;
  logic [NCNT_W-1:0] node_cnt_r, node_cnt_nxt;
  logic [ECNT_W-1:0] edge_cnt_r, edge_cnt_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  stop_t             stop_r, stop_nxt;
  logic [CLR_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic              clr_mark_r, clr_mark_nxt;
  logic              clr_vert_r, clr_vert_nxt;
  logic              clr_pend_r, clr_pend_nxt;
  logic              out_valid_r, out_valid_nxt;
  result_t           res_r, res_nxt;
  result_t           out_r, out_nxt;

  slot_req_t slot_req;
  vert_req_t vert_req;
  node_req_t node_req;
  edge_req_t edge_req;
  slot_ent_t slot_rd;
  vert_ent_t vert_rd;
  logic      node_rd;
  logic      edge_rd;

  logic              in_acc;
  logic [DEG_W-1:0]  deg_sat;
  logic [SLOT_W-1:0] deg_rot;
  stop_t             eff_stop;
  logic [DEG_W-1:0]  rot_inc;
  logic [SLOT_W-1:0] rot_new;
  logic              fn_flag;
  logic              fe_flag;
  logic [NCNT_W-1:0] node_cnt_inc;
  logic [ECNT_W-1:0] edge_cnt_inc;
  logic [STEP_W-1:0] step_inc;
  logic              clr_node_zone;

  rrw_adj_mem u_adj (
    .clk      (clk),
    .slot_req (slot_req),
    .slot_rd  (slot_rd),
    .vert_req (vert_req),
    .vert_rd  (vert_rd)
  );

  rrw_seen_mem u_seen (
    .clk      (clk),
    .node_req (node_req),
    .node_rd  (node_rd),
    .edge_req (edge_req),
    .edge_rd  (edge_rd)
  );

  // Handshakes
  assign in_chan.ready  = (state_r == FSM_IDLE);
  assign in_acc         = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;

  // Degree load: saturate, rotor starts one before slot zero
  assign deg_sat = (in_chan.degree > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE)
                                                          : in_chan.degree;
  assign deg_rot = (deg_sat == '0) ? '0 : SLOT_W'(deg_sat - DEG_W'(1));

  // Step entry: a walk that reached the limit unflagged stops here
  assign eff_stop = (stop_r == STOP_NONE && step_r == STEP_LIMIT) ? STOP_LIMIT : stop_r;

  // Rotor advance with wrap at the degree
  assign rot_inc = {1'b0, vert_rd.rot} + DEG_W'(1);
  assign rot_new = (rot_inc >= vert_rd.deg) ? '0 : rot_inc[SLOT_W-1:0];

  // Seen-map update values
  assign fn_flag      = !node_rd;
  assign fe_flag      = !edge_rd;
  assign node_cnt_inc = node_cnt_r + NCNT_W'(fn_flag);
  assign edge_cnt_inc = edge_cnt_r + ECNT_W'(fe_flag);
  assign step_inc     = step_r + STEP_W'(1);

  assign clr_node_zone = (clr_cnt_r < CLR_W'(MAX_NODES));

  // Next state, memory requests and register updates
  always_comb begin
    state_nxt     = state_r;
    src_nxt       = src_r;
    tgt_node_nxt  = tgt_node_r;
    tgt_edge_nxt  = tgt_edge_r;
    pos_nxt       = pos_r;
    node_cnt_nxt  = node_cnt_r;
    edge_cnt_nxt  = edge_cnt_r;
    step_nxt      = step_r;
    stop_nxt      = stop_r;
    clr_cnt_nxt   = clr_cnt_r;
    clr_mark_nxt  = clr_mark_r;
    clr_vert_nxt  = clr_vert_r;
    clr_pend_nxt  = clr_pend_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    slot_req      = '0;
    vert_req      = '0;
    node_req      = '0;
    edge_req      = '0;

    // Config writes; an index past the list is dropped
    if (cfg_chan.valid) begin
      case (cfg_idx_t'(cfg_chan.index))
        CFG_SOURCE:   src_nxt      = cfg_chan.data[NODE_W-1:0];
        CFG_TGT_NODE: tgt_node_nxt = cfg_chan.data[NCNT_W-1:0];
        CFG_TGT_EDGE: tgt_edge_nxt = cfg_chan.data[ECNT_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      FSM_CLEAR: begin
        // Sweep the maps one entry a cycle; mark the start vertex if requested
        edge_req.we   = 1'b1;
        edge_req.addr = clr_cnt_r;
        edge_req.wbit = 1'b0;
        node_req.we   = clr_node_zone;
        node_req.addr = clr_cnt_r[NODE_W-1:0];
        node_req.wbit = clr_mark_r && (clr_cnt_r[NODE_W-1:0] == pos_r);
        vert_req.we   = clr_vert_r && clr_node_zone;
        vert_req.addr = clr_cnt_r[NODE_W-1:0];
        vert_req.wdata = '0;
        clr_cnt_nxt   = clr_cnt_r + CLR_W'(1);
        if (clr_cnt_r == CLR_W'(MAX_EDGES - 1)) begin
          clr_vert_nxt = 1'b0;
          state_nxt    = FSM_IDLE;
        end
      end

      FSM_IDLE: begin
        if (in_acc) begin
          state_nxt = FSM_EMIT;
          case (mode_t'(in_chan.mode))
            MODE_LOAD_SLOT: begin
              slot_req.we             = 1'b1;
              slot_req.addr           = {in_chan.vertex, in_chan.slot};
              slot_req.wdata.neighbor = in_chan.neighbor;
              slot_req.wdata.edge_id  = in_chan.edge_index;
              res_nxt = mk_res('0, '0, '0, 1'b0, 1'b0, node_cnt_r, edge_cnt_r,
                               STAT_LOAD_ACK);
            end
            MODE_SET_DEGREE: begin
              vert_req.we        = 1'b1;
              vert_req.addr      = in_chan.vertex;
              vert_req.wdata.deg = deg_sat;
              vert_req.wdata.rot = deg_rot;
              res_nxt = mk_res('0, '0, '0, 1'b0, 1'b0, node_cnt_r, edge_cnt_r,
                               STAT_LOAD_ACK);
            end
            MODE_START: begin
              pos_nxt      = src_r;
              node_cnt_nxt = NCNT_W'(1);
              edge_cnt_nxt = '0;
              step_nxt     = '0;
              stop_nxt     = (tgt_node_r == NCNT_W'(1) && tgt_edge_r == '0) ?
                             STOP_COMPLETE : STOP_NONE;
              clr_mark_nxt = 1'b1;
              clr_pend_nxt = 1'b1;
              clr_cnt_nxt  = '0;
              res_nxt = mk_res('0, src_r, '0, 1'b1, 1'b0, NCNT_W'(1), '0,
                               status_t'({1'b0, stop_nxt}));
            end
            MODE_STEP: begin
              if (eff_stop != STOP_NONE) begin
                stop_nxt = eff_stop;
                res_nxt  = mk_res('0, pos_r, step_r, 1'b0, 1'b0, node_cnt_r, edge_cnt_r,
                                  status_t'({1'b0, eff_stop}));
              end else begin
                vert_req.re   = 1'b1;
                vert_req.addr = pos_r;
                state_nxt     = FSM_VERT;
              end
            end
            default: ;
          endcase
        end
      end

      FSM_VERT: begin
        if (vert_rd.deg == '0) begin
          // Sink: no way out of this vertex
          stop_nxt  = STOP_SINK;
          res_nxt   = mk_res('0, pos_r, step_r, 1'b0, 1'b0, node_cnt_r, edge_cnt_r,
                             STAT_SINK);
          state_nxt = FSM_EMIT;
        end else begin
          vert_req.we        = 1'b1;
          vert_req.addr      = pos_r;
          vert_req.wdata.deg = vert_rd.deg;
          vert_req.wdata.rot = rot_new;
          slot_req.re        = 1'b1;
          slot_req.addr      = {pos_r, rot_new};
          state_nxt          = FSM_SLOT;
        end
      end

      FSM_SLOT: begin
        node_req.re   = 1'b1;
        node_req.addr = slot_rd.neighbor;
        edge_req.re   = 1'b1;
        edge_req.addr = slot_rd.edge_id;
        state_nxt     = FSM_SEEN;
      end

      FSM_SEEN: begin
        // Mark both maps, move the walker, bump counters and judge the stop
        node_req.we   = 1'b1;
        node_req.addr = slot_rd.neighbor;
        node_req.wbit = 1'b1;
        edge_req.we   = 1'b1;
        edge_req.addr = slot_rd.edge_id;
        edge_req.wbit = 1'b1;
        pos_nxt       = slot_rd.neighbor;
        node_cnt_nxt  = node_cnt_inc;
        edge_cnt_nxt  = edge_cnt_inc;
        step_nxt      = step_inc;
        if (node_cnt_inc == tgt_node_r && edge_cnt_inc == tgt_edge_r) begin
          stop_nxt = STOP_COMPLETE;
        end else if (step_inc == STEP_LIMIT) begin
          stop_nxt = STOP_LIMIT;
        end else begin
          stop_nxt = STOP_NONE;
        end
        res_nxt = mk_res(slot_rd.edge_id, slot_rd.neighbor, step_inc, fn_flag, fe_flag,
                         node_cnt_inc, edge_cnt_inc, status_t'({1'b0, stop_nxt}));
        state_nxt = FSM_EMIT;
      end

      FSM_EMIT: begin
        // Hand the result over once the output register is free
        if (!out_valid_r || out_chan.ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          clr_pend_nxt  = 1'b0;
          state_nxt     = clr_pend_r ? FSM_CLEAR : FSM_IDLE;
        end
      end

      default: state_nxt = FSM_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_CLEAR;
      src_r       <= '0;
      tgt_node_r  <= NCNT_W'(1);
      tgt_edge_r  <= '0;
      pos_r       <= '0;
      node_cnt_r  <= '0;
      edge_cnt_r  <= '0;
      step_r      <= '0;
      stop_r      <= STOP_NONE;
      clr_cnt_r   <= '0;
      clr_mark_r  <= 1'b0;
      clr_vert_r  <= 1'b1;
      clr_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      src_r       <= src_nxt;
      tgt_node_r  <= tgt_node_nxt;
      tgt_edge_r  <= tgt_edge_nxt;
      pos_r       <= pos_nxt;
      node_cnt_r  <= node_cnt_nxt;
      edge_cnt_r  <= edge_cnt_nxt;
      step_r      <= step_nxt;
      stop_r      <= stop_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_mark_r  <= clr_mark_nxt;
      clr_vert_r  <= clr_vert_nxt;
      clr_pend_r  <= clr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload registers
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.edge_id          = out_r.edge_id;
  assign out_chan.arrival_vertex   = out_r.arrival_vertex;
  assign out_chan.step_number      = out_r.step_number;
  assign out_chan.first_node_visit = out_r.first_node_visit;
  assign out_chan.first_edge_visit = out_r.first_edge_visit;
  assign out_chan.nodes_seen       = out_r.nodes_seen;
  assign out_chan.edges_seen       = out_r.edges_seen;
  assign out_chan.status           = out_r.status;

  // A stopped walk stays stopped until a new start transaction
  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (stop_r != STOP_NONE &&
     !(in_acc && mode_t'(in_chan.mode) == MODE_START)) |=> stop_r != STOP_NONE)
    else $error("stop code cleared without a start");

  // A new result shows up only out of the result stage
  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == FSM_EMIT)
    else $error("output raised outside the result stage");

  // Each completed move advances the step counter by exactly one
  a_step_advance: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == FSM_SEEN |=> step_r == $past(step_r) + STEP_W'(1))
    else $error("step counter did not advance on a move");

endmodule

FILE: tb/sv/rrw_walk_checker.sv
// Scoreboard for the rotor-router walk engine: predicts each result and compares it.
// Watches the item, result and config channels; depends on rrw_pkg and the rrw_if interfaces.
module rrw_walk_checker import rrw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  rrw_in_if           in_mon,
  rrw_out_if          out_mon,
  rrw_cfg_if          cfg_mon,
  output int unsigned fail_count,
  output int unsigned pending
);

  typedef struct packed {
    logic [EDGE_W-1:0] edge_id;
    logic [NODE_W-1:0] arrival;
    logic [STEP_W-1:0] step;
    logic              first_node;
    logic              first_edge;
    logic [NCNT_W-1:0] nodes;
    logic [ECNT_W-1:0] edges;
    logic [STAT_W-1:0] status;
  } walk_result_t;

  // Adjacency table and walk state as the engine holds them
  logic [NODE_W-1:0] nb_tab    [SLOT_DEPTH];
  logic [EDGE_W-1:0] edge_tab  [SLOT_DEPTH];
  logic [DEG_W-1:0]  deg_tab   [MAX_NODES];
  logic [SLOT_W-1:0] rotor_tab [MAX_NODES];
  bit                node_seen [MAX_NODES];
  bit                edge_seen [MAX_EDGES];
  logic [NODE_W-1:0] walker;
  logic [NCNT_W-1:0] nodes_cnt;
  logic [ECNT_W-1:0] edges_cnt;
  logic [STEP_W-1:0] step_cnt;
  stop_t             stop_state;

  // Register copies
  logic [NODE_W-1:0] cfg_source;
  logic [NCNT_W-1:0] cfg_tgt_nodes;
  logic [ECNT_W-1:0] cfg_tgt_edges;

  walk_result_t pending_results[$];
  walk_result_t want;

  initial fail_count = 0;
  initial pending = 0;

  function automatic bit targets_reached();
    return nodes_cnt == cfg_tgt_nodes && edges_cnt == cfg_tgt_edges;
  endfunction

  // Apply one transaction to the walk state and return the result it produces
  function automatic walk_result_t advance_walk(mode_t m, logic [NODE_W-1:0] v,
                                                logic [SLOT_W-1:0] s, logic [NODE_W-1:0] nb,
                                                logic [EDGE_W-1:0] ei, logic [DEG_W-1:0] dg);
    walk_result_t r;
    logic [DEG_W-1:0] d;
    logic [NODE_W-1:0] here;
    logic [SLOT_AW-1:0] idx;
    int unsigned nxt;
    r = '0;
    case (m)
      MODE_LOAD_SLOT: begin
        nb_tab[{v, s}] = nb;
        edge_tab[{v, s}] = ei;
        r.status = STAT_LOAD_ACK;
      end
      MODE_SET_DEGREE: begin
        // saturate the degree and park the rotor on the last slot
        d = (dg > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : dg;
        deg_tab[v] = d;
        rotor_tab[v] = (d != '0) ? SLOT_W'(d - 5'd1) : '0;
        r.status = STAT_LOAD_ACK;
      end
      MODE_START: begin
        foreach (node_seen[i]) node_seen[i] = 1'b0;
        foreach (edge_seen[i]) edge_seen[i] = 1'b0;
        walker = cfg_source;
        node_seen[cfg_source] = 1'b1;
        nodes_cnt = NCNT_W'(1);
        edges_cnt = '0;
        step_cnt = '0;
        stop_state = targets_reached() ? STOP_COMPLETE : STOP_NONE;
        r.arrival = cfg_source;
        r.first_node = 1'b1;
        r.status = STAT_W'(stop_state);
      end
      default: begin
        here = walker;
        if (stop_state == STOP_NONE && step_cnt >= STEP_LIMIT) stop_state = STOP_LIMIT;
        if (stop_state == STOP_NONE && deg_tab[here] == '0) stop_state = STOP_SINK;
        if (stop_state != STOP_NONE) begin
          // stopped or stuck: hold the walker in place
          r.arrival = here;
          r.step = step_cnt;
          r.status = STAT_W'(stop_state);
        end else begin
          nxt = (int'(rotor_tab[here]) + 1) % int'(deg_tab[here]);
          rotor_tab[here] = SLOT_W'(nxt);
          idx = {here, SLOT_W'(nxt)};
          walker = nb_tab[idx];
          r.edge_id = edge_tab[idx];
          r.arrival = walker;
          step_cnt = step_cnt + 1'b1;
          if (!edge_seen[r.edge_id]) begin
            edge_seen[r.edge_id] = 1'b1;
            edges_cnt = edges_cnt + 1'b1;
            r.first_edge = 1'b1;
          end
          if (!node_seen[walker]) begin
            node_seen[walker] = 1'b1;
            nodes_cnt = nodes_cnt + 1'b1;
            r.first_node = 1'b1;
          end
          // completion wins over the step limit
          if (targets_reached()) stop_state = STOP_COMPLETE;
          else if (step_cnt >= STEP_LIMIT) stop_state = STOP_LIMIT;
          r.step = step_cnt;
          r.status = STAT_W'(stop_state);
        end
      end
    endcase
    r.nodes = nodes_cnt;
    r.edges = edges_cnt;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_source = '0;
      cfg_tgt_nodes = NCNT_W'(1);
      cfg_tgt_edges = '0;
      foreach (nb_tab[i]) begin
        nb_tab[i] = '0;
        edge_tab[i] = '0;
      end
      foreach (deg_tab[i]) begin
        deg_tab[i] = '0;
        rotor_tab[i] = '0;
        node_seen[i] = 1'b0;
      end
      foreach (edge_seen[i]) edge_seen[i] = 1'b0;
      walker = '0;
      nodes_cnt = '0;
      edges_cnt = '0;
      step_cnt = '0;
      stop_state = STOP_NONE;
      pending_results.delete();
    end else begin
      // compare a delivered result with the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        if (pending_results.size() == 0) begin
          $error("result with no pending transaction: arrival %0d status %0d",
                 out_mon.arrival_vertex, out_mon.status);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("edge_id", want.edge_id, out_mon.edge_id);
          check_field("arrival_vertex", want.arrival, out_mon.arrival_vertex);
          check_field("step_number", want.step, out_mon.step_number);
          check_field("first_node_visit", want.first_node, out_mon.first_node_visit);
          check_field("first_edge_visit", want.first_edge, out_mon.first_edge_visit);
          check_field("nodes_seen", want.nodes, out_mon.nodes_seen);
          check_field("edges_seen", want.edges, out_mon.edges_seen);
          check_field("status", want.status, out_mon.status);
        end
      end
      // track register writes
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_idx_t'(cfg_mon.index))
          CFG_SOURCE:   cfg_source = cfg_mon.data[NODE_W-1:0];
          CFG_TGT_NODE: cfg_tgt_nodes = cfg_mon.data[NCNT_W-1:0];
          CFG_TGT_EDGE: cfg_tgt_edges = cfg_mon.data[ECNT_W-1:0];
          default: ;
        endcase
      end
      // predict the result of an accepted item
      if (in_mon.valid && in_mon.ready)
        pending_results.push_back(advance_walk(mode_t'(in_mon.mode), in_mon.vertex,
                                               in_mon.slot, in_mon.neighbor,
                                               in_mon.edge_index, in_mon.degree));
    end
    pending = pending_results.size();
  end

endmodule

FILE: tb/sv/tb_top.sv
// Testbench top for the rotor-router walk engine: clock, reset, stimulus and verdict.
// Needs rrw_pkg, the rrw_if interfaces, the engine RTL and rrw_walk_checker.
module tb_top;
  import rrw_pkg::*;

  localparam int unsigned ITEM_TARGET   = 1250;
  localparam int unsigned QUIET_FROM    = 1100;
  localparam int unsigned SETTLE_CYCLES = 600;
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned DRAIN_CYCLES  = 50;
  localparam int unsigned LONG_HOLD     = 300;

  logic clk;
  logic rst_n;
  int unsigned fail_count;
  int unsigned pending;

  rrw_in_if  in_if();
  rrw_out_if out_if();
  rrw_cfg_if cfg_if();

  rotor_router_walk_engine_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  rrw_walk_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .cfg_mon    (cfg_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Stimulus bookkeeping
  bit          slot_written [MAX_NODES][MAX_DEGREE];
  int unsigned items_sent;
  bit          quiet;
  bit          in_gaps_on;
  int unsigned hold_reqs;
  int unsigned hold_done;
  int unsigned hold_left;
  int unsigned burst_left;
  int unsigned calm_left;
  int unsigned stall_cycles;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Result-side ready: random stall bursts, calm stretches, and long holds on request
  always @(negedge clk) begin
    if (hold_done != hold_reqs) begin
      hold_done++;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left--;
    end else if (quiet || calm_left > 0) begin
      out_if.ready <= 1'b1;
      if (calm_left > 0) calm_left--;
    end else if (burst_left > 0) begin
      out_if.ready <= 1'b0;
      burst_left--;
    end else begin
      case ($urandom_range(0, 15))
        0, 1: begin
          burst_left = $urandom_range(1, 14) - 1;
          out_if.ready <= 1'b0;
        end
        2: begin
          calm_left = $urandom_range(20, 120);
          out_if.ready <= 1'b1;
        end
        default: out_if.ready <= 1'b1;
      endcase
    end
  end

  // Abort when nothing moves on any channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Offer one item, with an optional idle burst first; returns at the next falling edge
  task automatic send_item(mode_t m, int unsigned v, int unsigned s, int unsigned nb,
                           int unsigned ei, int unsigned dg);
    if (!quiet && in_gaps_on && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.mode       <= m;
    in_if.vertex     <= NODE_W'(v);
    in_if.slot       <= SLOT_W'(s);
    in_if.neighbor   <= NODE_W'(nb);
    in_if.edge_index <= EDGE_W'(ei);
    in_if.degree     <= DEG_W'(dg);
    if (m == MODE_LOAD_SLOT) slot_written[v % MAX_NODES][s % MAX_DEGREE] = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    items_sent++;
    if (items_sent >= QUIET_FROM) quiet = 1'b1;
    @(negedge clk);
  endtask

  // Random item of any kind; a degree never exceeds the slots already written
  task automatic noise_item();
    mode_t m;
    int unsigned v;
    int unsigned p;
    m = mode_t'($urandom_range(0, 3));
    v = $urandom_range(0, MAX_NODES - 1);
    p = 0;
    if (m == MODE_SET_DEGREE) begin
      while (p < MAX_DEGREE && slot_written[v][p]) p++;
      send_item(m, v, $urandom, $urandom, $urandom,
                (p == MAX_DEGREE) ? $urandom_range(0, 31) : $urandom_range(0, p));
    end else begin
      send_item(m, v, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  task automatic send_mixed(mode_t m, int unsigned v, int unsigned s, int unsigned nb,
                            int unsigned ei, int unsigned dg);
    if ($urandom_range(0, 9) == 0) noise_item();
    send_item(m, v, s, nb, ei, dg);
  endtask

  // Stop offering items until every predicted result has been delivered
  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic cfg_write(cfg_idx_t idx, int unsigned d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= CDAT_W'(d);
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
  endtask

  // Write all three registers with the engine idle
  task automatic configure(int unsigned src, int unsigned tn, int unsigned te);
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_write(CFG_SOURCE, src);
    cfg_write(CFG_TGT_NODE, tn);
    cfg_write(CFG_TGT_EDGE, te);
    cfg_if.valid <= 1'b0;
  endtask

  // Build a small graph, strongly connected unless a vertex sinks, load it, then usually start and walk it
  task automatic run_walk_phase(int unsigned phase);
    int unsigned n;
    int unsigned n_steps;
    int unsigned distinct;
    int          sink_at;
    bit          dup;
    bit          used_edge [MAX_EDGES];
    int unsigned verts [8];
    int unsigned degs [8];
    int unsigned nbs [8][MAX_DEGREE];
    int unsigned eids [8][MAX_DEGREE];
    int unsigned last_eid;
    in_gaps_on = ($urandom_range(0, 3) != 0);
    n = $urandom_range(2, 6);
    distinct = 0;
    last_eid = $urandom_range(0, MAX_EDGES - 1);
    for (int i = 0; i < n; i++) begin
      do begin
        verts[i] = $urandom_range(0, MAX_NODES - 1);
        dup = 1'b0;
        for (int k = 0; k < i; k++) if (verts[k] == verts[i]) dup = 1'b1;
      end while (dup);
      degs[i] = ($urandom_range(0, 9) == 0) ? MAX_DEGREE : $urandom_range(1, 3);
    end
    // occasionally leave one vertex without exits so the walk can sink
    sink_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, n - 1) : -1;
    if (sink_at >= 0) degs[sink_at] = 0;
    // slot 0 closes a ring through all vertices; other slots point anywhere in the graph
    for (int i = 0; i < n; i++) begin
      for (int s = 0; s < degs[i]; s++) begin
        nbs[i][s] = (s == 0) ? verts[(i + 1) % n] : verts[$urandom_range(0, n - 1)];
        eids[i][s] = ($urandom_range(0, 5) == 0) ? last_eid : $urandom_range(0, MAX_EDGES - 1);
        last_eid = eids[i][s];
        if (!used_edge[eids[i][s]]) begin
          used_edge[eids[i][s]] = 1'b1;
          distinct++;
        end
      end
    end
    if (phase == 0 || $urandom_range(0, 19) < 17) begin
      case ($urandom_range(0, 5))
        0: configure($urandom, $urandom, $urandom);
        1: configure($urandom_range(0, 1) ? 1023 : 0, $urandom_range(0, 1) ? 1023 : 0,
                     $urandom_range(0, 1) ? 1023 : 0);
        default: configure(verts[0], n, distinct);
      endcase
    end
    for (int i = 0; i < n; i++)
      for (int s = 0; s < degs[i]; s++)
        send_mixed(MODE_LOAD_SLOT, verts[i], s, nbs[i][s], eids[i][s], $urandom);
    for (int i = 0; i < n; i++)
      send_mixed(MODE_SET_DEGREE, verts[i], $urandom, $urandom, $urandom,
                 (degs[i] == MAX_DEGREE) ? $urandom_range(16, 31) : degs[i]);
    // now and then skip the start and keep walking from wherever the walker is
    if ($urandom_range(0, 9) != 0)
      send_mixed(MODE_START, $urandom, $urandom, $urandom, $urandom, $urandom);
    // hold off the result side once so the engine backs up into the input
    if (phase == 2) hold_reqs++;
    n_steps = $urandom_range(10, 60);
    for (int k = 0; k < n_steps; k++)
      send_mixed(MODE_STEP, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    int unsigned phase;
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.mode       = MODE_LOAD_SLOT;
    in_if.vertex     = '0;
    in_if.slot       = '0;
    in_if.neighbor   = '0;
    in_if.edge_index = '0;
    in_if.degree     = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = CFG_SOURCE;
    cfg_if.data      = '0;
    out_if.ready     = 1'b0;
    items_sent       = 0;
    quiet            = 1'b0;
    in_gaps_on       = 1'b1;
    hold_reqs        = 0;
    hold_done        = 0;
    hold_left        = 0;
    burst_left       = 0;
    calm_left        = 0;
    stall_cycles     = 0;
    phase            = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Step before any start: vertex 0 has no exits, so the walk sinks and stays put
    send_item(MODE_STEP, $urandom, $urandom, $urandom, $urandom, $urandom);
    send_item(MODE_STEP, $urandom, $urandom, $urandom, $urandom, $urandom);
    // Reset targets are met by the source alone, so the walk completes at start
    send_item(MODE_START, $urandom, $urandom, $urandom, $urandom, $urandom);
    send_item(MODE_STEP, $urandom, $urandom, $urandom, $urandom, $urandom);
    // Vertex 255: self loops on every slot but the last, which leads to vertex 0
    for (int k = 0; k < MAX_DEGREE; k++)
      send_item(MODE_LOAD_SLOT, 255, k, (k == MAX_DEGREE - 1) ? 0 : 255,
                (k == MAX_DEGREE - 1) ? 0 : 511 - k, $urandom);
    // An oversized degree saturates to the full slot count
    send_item(MODE_SET_DEGREE, 255, $urandom, $urandom, $urandom, 31);
    configure(255, 256, 512);
    send_item(MODE_START, $urandom, $urandom, $urandom, $urandom, $urandom);
    send_item(MODE_STEP, $urandom, $urandom, $urandom, $urandom, $urandom);
    send_item(MODE_STEP, $urandom, $urandom, $urandom, $urandom, $urandom);

    while (items_sent < ITEM_TARGET) begin
      run_walk_phase(phase);
      phase++;
    end

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

FILE: rotor_router_walk_engine_top.f
hdl/rrw_pkg.sv
hdl/rrw_if.sv
hdl/rrw_adj_mem.sv
hdl/rrw_seen_mem.sv
hdl/rotor_router_walk_engine_top.sv
tb/sv/rrw_walk_checker.sv
tb/sv/tb_top.sv
